// ----- rtl/pdll_pkg.sv -----
package pdll_pkg;
   localparam int PoolDepth = 32;
   localparam int SlotW = $clog2(PoolDepth);
   localparam int CountW = $clog2(PoolDepth + 1);
   localparam int PosW = 7;
   localparam int ValW = 32;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_DUMP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_FULL    = 2'd2,
      ST_EMPTY   = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [PosW-1:0]   position;
      logic [ValW-1:0]   value;
   } op_type;
endpackage

// ----- rtl/pdll_front.sv -----
module pdll_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  pdll_pkg::op_type  in_op,
   output logic              q_valid,
   input  logic              q_ready,
   output pdll_pkg::op_type  q_op
);
   import pdll_pkg::*;

   // two-entry queue
   op_type     mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_op     = mem_ff[rp_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= in_op;
      end
   end
endmodule

// ----- rtl/pdll_back.sv -----
module pdll_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   output logic                         q_ready,
   input  pdll_pkg::op_type             q_op,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [1:0]                   out_status,
   output logic [pdll_pkg::ValW-1:0]    out_value,
   output logic [pdll_pkg::PosW-1:0]    out_count,
   output logic                         out_last
);
   import pdll_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_WALK = 6'b000010,
      S_LINK = 6'b000100,
      S_DUMP = 6'b001000,
      S_EMIT = 6'b010000,
      S_FIN  = 6'b100000
   } state_type;

   logic [ValW-1:0]  val_ff  [PoolDepth];
   logic [SlotW-1:0] nxt_ff  [PoolDepth];
   logic [SlotW-1:0] prv_ff  [PoolDepth];
   logic [PoolDepth-1:0] used_ff;
   logic [SlotW-1:0] head_ff, tail_ff;
   logic [CountW-1:0] count_ff;

   state_type state_ff;
   op_type    op_ff;
   logic [SlotW-1:0] cur_ff;
   logic [PosW-1:0]  step_ff;
   logic [PosW-1:0]  target_ff;
   logic [SlotW-1:0] free_slot;

   logic              ov_ff;
   logic [1:0]        os_ff;
   logic [ValW-1:0]   oval_ff;
   logic [PosW-1:0]   ocnt_ff;
   logic              olast_ff;

   logic [PosW-1:0] cnt_w;
   logic [PosW-1:0] eff_pos;
   logic            is_ins;

   assign cnt_w = PosW'(count_ff);
   assign out_valid  = ov_ff;
   assign out_status = os_ff;
   assign out_value  = oval_ff;
   assign out_count  = ocnt_ff;
   assign out_last   = olast_ff;
   assign q_ready    = (state_ff == S_IDLE) && !ov_ff;
   assign is_ins     = (q_op.cmd == CMD_INSERT) || (q_op.cmd == CMD_APPEND);
   assign eff_pos    = (q_op.cmd == CMD_APPEND) ? cnt_w : q_op.position;

   always_comb begin
      free_slot = '0;
      for (int i = PoolDepth - 1; i >= 0; i--) begin
         if (!used_ff[i]) free_slot = SlotW'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         ov_ff    <= 1'b0;
      end else begin
         if (ov_ff && out_ready && state_ff != S_DUMP) ov_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid && q_ready) begin
                  op_ff     <= q_op;
                  cur_ff    <= head_ff;
                  step_ff   <= '0;
                  oval_ff   <= '0;
                  olast_ff  <= 1'b1;
                  if (q_op.cmd == CMD_DUMP) begin
                     if (count_ff == '0) begin
                        os_ff   <= ST_EMPTY;
                        ocnt_ff <= '0;
                        ov_ff   <= 1'b1;
                     end else begin
                        os_ff    <= ST_OK;
                        state_ff <= S_DUMP;
                     end
                  end else if (is_ins) begin
                     if (eff_pos > cnt_w) begin
                        os_ff <= ST_INVALID; ocnt_ff <= cnt_w; ov_ff <= 1'b1;
                     end else if (cnt_w >= PosW'(PoolDepth)) begin
                        os_ff <= ST_FULL; ocnt_ff <= cnt_w; ov_ff <= 1'b1;
                     end else begin
                        os_ff    <= ST_OK;
                        state_ff <= (eff_pos > 1 && eff_pos != cnt_w) ? S_WALK : S_LINK;
                        target_ff <= eff_pos - 1'b1;
                     end
                  end else begin
                     if (count_ff == '0) begin
                        os_ff <= ST_EMPTY; ocnt_ff <= cnt_w; ov_ff <= 1'b1;
                     end else if (q_op.position >= cnt_w) begin
                        os_ff <= ST_INVALID; ocnt_ff <= cnt_w; ov_ff <= 1'b1;
                     end else begin
                        os_ff     <= ST_OK;
                        target_ff <= q_op.position;
                        state_ff  <= (q_op.position != '0) ? S_WALK : S_LINK;
                     end
                  end
               end
            end
            S_WALK: begin
               cur_ff  <= nxt_ff[cur_ff];
               step_ff <= step_ff + 1'b1;
               if (step_ff + 1'b1 == target_ff) state_ff <= S_LINK;
            end
            S_LINK: begin
               if (op_ff.cmd == CMD_DELETE) begin
                  used_ff[cur_ff] <= 1'b0;
                  if (count_ff == CountW'(1)) begin
                     head_ff <= '0; tail_ff <= '0;
                  end else if (target_ff == '0) begin
                     head_ff <= nxt_ff[cur_ff];
                  end else if (target_ff == cnt_w - 1'b1) begin
                     tail_ff <= prv_ff[cur_ff];
                  end else begin
                     nxt_ff[prv_ff[cur_ff]] <= nxt_ff[cur_ff];
                     prv_ff[nxt_ff[cur_ff]] <= prv_ff[cur_ff];
                  end
                  count_ff <= count_ff - 1'b1;
                  ocnt_ff  <= cnt_w - 1'b1;
               end else begin
                  // target_ff holds position-1 here
                  val_ff[free_slot]  <= op_ff.value;
                  used_ff[free_slot] <= 1'b1;
                  if (count_ff == '0) begin
                     head_ff <= free_slot; tail_ff <= free_slot;
                  end else if (target_ff == {PosW{1'b1}}) begin
                     nxt_ff[free_slot] <= head_ff;
                     prv_ff[head_ff]   <= free_slot;
                     head_ff           <= free_slot;
                  end else if (target_ff + 1'b1 == cnt_w) begin
                     prv_ff[free_slot] <= tail_ff;
                     nxt_ff[tail_ff]   <= free_slot;
                     tail_ff           <= free_slot;
                  end else begin
                     nxt_ff[free_slot]      <= nxt_ff[cur_ff];
                     prv_ff[free_slot]      <= cur_ff;
                     nxt_ff[cur_ff]         <= free_slot;
                     prv_ff[nxt_ff[cur_ff]] <= free_slot;
                  end
                  count_ff <= count_ff + 1'b1;
                  ocnt_ff  <= cnt_w + 1'b1;
               end
               ov_ff    <= 1'b1;
               state_ff <= S_FIN;
            end
            S_DUMP: begin
               if (!ov_ff || out_ready) begin
                  oval_ff  <= val_ff[cur_ff];
                  ocnt_ff  <= cnt_w;
                  olast_ff <= (step_ff + 1'b1 == cnt_w);
                  ov_ff    <= 1'b1;
                  cur_ff   <= nxt_ff[cur_ff];
                  step_ff  <= step_ff + 1'b1;
                  state_ff <= (step_ff + 1'b1 == cnt_w) ? S_FIN : S_EMIT;
               end
            end
            S_EMIT: begin
               state_ff <= S_DUMP;
            end
            S_FIN: begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ----- rtl/positional_doubly_linked_list_core.sv -----
// Doubly linked list of signed 32-bit values in a pool of PoolDepth nodes.
// Commands on req_tdata: insert at index, append, delete at index, dump.
// Commands queue in a two-entry buffer; the list engine handles one at a
// time, walking one link per cycle. An insert inside the list at index p
// walks to index p-1 and a delete at index p walks to index p (a tail
// delete walks the whole list); head inserts, appends and head deletes
// link without a walk. A dump delivers its values one at a time and waits
// while a response is not taken. Each command gives one response except
// a dump of a non-empty list, one response per element; rsp_tlast marks the final one.
module positional_doubly_linked_list_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // cmd[1:0], position[8:2], value[40:9], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // status[1:0], item_value[33:2], count[40:34], pad
   output logic        rsp_tlast
);
   import pdll_pkg::*;

   op_type in_op, q_op;
   logic   q_valid, q_ready;
   logic [1:0]      st;
   logic [ValW-1:0] v;
   logic [PosW-1:0] c;

   assign in_op.cmd      = cmd_type'(req_tdata[1:0]);
   assign in_op.position = req_tdata[8:2];
   assign in_op.value    = req_tdata[40:9];

   pdll_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_op,
      .q_valid, .q_ready, .q_op
   );

   pdll_back u_back (
      .clock, .reset,
      .q_valid, .q_ready, .q_op,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_status(st), .out_value(v), .out_count(c), .out_last(rsp_tlast)
   );

   assign rsp_tdata = {7'd0, c, v, st};
endmodule

// ----- tb/tb_positional_doubly_linked_list_core.sv -----
`timescale 1ns / 1ps

module tb_positional_doubly_linked_list_core;
   import pdll_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // cmd[1:0], position[8:2], value[40:9], pad
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;   // status[1:0], item_value[33:2], count[40:34], pad
   logic        rsp_tlast;

   typedef struct packed {
      status_type  status;
      logic [31:0] item_value;
      logic [6:0]  count;
      logic        last;
   } reply_type;

   reply_type   replies_due[$];
   logic [31:0] list_values[$];
   int          mismatches = 0;
   int          cycles = 0;
   int          send_idle_pct;
   int          recv_idle_pct;

   positional_doubly_linked_list_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic reply_type make_reply(status_type st, logic [31:0] v, logic lst);
      reply_type r;
      r.status = st;
      r.item_value = v;
      r.count = 7'(list_values.size());
      r.last = lst;
      return r;
   endfunction

   // list kept as a plain ordered queue; slot layout is not visible at the ports
   task automatic predict_list_op(cmd_type cmd, logic [6:0] pos, logic [31:0] v);
      int n;
      n = list_values.size();
      case (cmd)
         CMD_INSERT, CMD_APPEND: begin
            if (cmd == CMD_APPEND) pos = 7'(n);
            if (pos > n) replies_due.push_back(make_reply(ST_INVALID, '0, 1'b1));
            else if (n >= PoolDepth) replies_due.push_back(make_reply(ST_FULL, '0, 1'b1));
            else begin
               list_values.insert(pos, v);
               replies_due.push_back(make_reply(ST_OK, '0, 1'b1));
            end
         end
         CMD_DELETE: begin
            if (n == 0) replies_due.push_back(make_reply(ST_EMPTY, '0, 1'b1));
            else if (pos >= n) replies_due.push_back(make_reply(ST_INVALID, '0, 1'b1));
            else begin
               list_values.delete(pos);
               replies_due.push_back(make_reply(ST_OK, '0, 1'b1));
            end
         end
         default: begin
            if (n == 0) replies_due.push_back(make_reply(ST_EMPTY, '0, 1'b1));
            else
               for (int i = 0; i < n; i++)
                  replies_due.push_back(make_reply(ST_OK, list_values[i], i == n - 1));
         end
      endcase
   endtask

   task automatic send_op(cmd_type cmd, logic [6:0] pos, logic [31:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, v, pos, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_list_op(cmd, pos, v);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      rsp_tready <= reset ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         reply_type got, want;
         got.status = status_type'(rsp_tdata[1:0]);
         got.item_value = rsp_tdata[33:2];
         got.count = rsp_tdata[40:34];
         got.last = rsp_tlast;
         if (replies_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item %h", got);
         end else begin
            want = replies_due.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp st=%0d v=%h cnt=%0d last=%b got st=%0d v=%h cnt=%0d last=%b",
                           want.status, want.item_value, want.count, want.last,
                           got.status, got.item_value, got.count, got.last);
            end
         end
      end
      if (cycles > 400000) begin
         $display("positional_doubly_linked_list_core regression: fail");
         $finish;
      end
   end

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_op(CMD_DUMP, 7'd0, 32'd0);
      send_op(CMD_DELETE, 7'd127, 32'd0);
      send_op(CMD_INSERT, 7'd1, 32'h1);
      send_op(CMD_INSERT, 7'd0, 32'h8000_0000);
      send_op(CMD_APPEND, 7'd127, 32'h7fff_ffff);
      send_op(CMD_INSERT, 7'd2, 32'hffff_ffff);
      send_op(CMD_INSERT, 7'd1, 32'h0);
      send_op(CMD_DUMP, 7'd0, 32'd0);
      send_op(CMD_DELETE, 7'd4, 32'd0);
      send_op(CMD_DELETE, 7'd3, 32'd0);
      send_op(CMD_DELETE, 7'd1, 32'd0);
      send_op(CMD_DELETE, 7'd0, 32'd0);
      send_op(CMD_DUMP, 7'd0, 32'd0);
      send_op(CMD_DELETE, 7'd0, 32'd0);
      send_op(CMD_DUMP, 7'd0, 32'd0);
      wait_drained();
   endtask

   task automatic test_full_pool();
      for (int i = 0; i < PoolDepth; i++) send_op(CMD_APPEND, 7'd0, $urandom);
      send_op(CMD_APPEND, 7'd0, 32'h5a5a_5a5a);
      send_op(CMD_INSERT, 7'd32, 32'h1234);
      send_op(CMD_INSERT, 7'd33, 32'h1234);
      send_op(CMD_DELETE, 7'd64, 32'd0);
      send_op(CMD_DUMP, 7'd0, 32'd0);
      wait_drained();
   endtask

   task automatic test_random(int n);
      int r, sz;
      logic [6:0] pos;
      for (int i = 0; i < n; i++) begin
         sz = list_values.size();
         r = $urandom_range(99);
         pos = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(sz));
         if (r < 35) send_op(CMD_INSERT, pos, $urandom);
         else if (r < 55) send_op(CMD_APPEND, 7'($urandom), $urandom);
         else if (r < 90) send_op(CMD_DELETE, pos, $urandom);
         else send_op(CMD_DUMP, 7'($urandom), $urandom);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      send_idle_pct = 7;
      recv_idle_pct = 74;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_pool();
      test_random(120);
      send_idle_pct = 74;
      recv_idle_pct = 7;
      test_random(110);
      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(110);
      wait_drained();
      repeat (100) @(posedge clock);
      if (mismatches == 0 && replies_due.size() == 0)
         $display("positional_doubly_linked_list_core regression: pass");
      else
         $display("positional_doubly_linked_list_core regression: fail");
      $finish;
   end
endmodule

// ----- files.f -----
rtl/pdll_pkg.sv
rtl/pdll_front.sv
rtl/pdll_back.sv
rtl/positional_doubly_linked_list_core.sv
tb/tb_positional_doubly_linked_list_core.sv
